// ===== rtl/bia_pkg.sv =====
// Shared request and status codes and field widths for the identifier allocator.
`default_nettype none

package bia_pkg;

    localparam int REQ_W     = 1;
    localparam int FREE_ID_W = 15;
    localparam int STATUS_W  = 2;
    localparam int ID_W      = 15;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_ALLOC = 1'b0;
    localparam req_t REQ_FREE  = 1'b1;

    localparam status_t ST_ALLOCATED = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_FREED     = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/bia_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the bitmap identifier allocator.
`default_nettype none

// An allocate transaction returns the lowest clear identifier at or above the
// search hint, or reports full; a free transaction clears an identifier's bit
// and lowers the hint to it if it lies below the hint. The bitmap sits in one
// single-port RAM of WORD_BITS-bit words that is read, modified and written
// back one word per cycle. After reset a clearing pass writes every word once
// with busy high. An allocate scans the words from the hint word up to the
// word holding the first clear bit; a free steps through S_FDIV, S_FREAD and
// S_FREE; an allocate while the hint already sits at the end of the range, and
// a free of an identifier outside the range, are answered straight from idle.
// done is high for exactly one cycle and cannot be held off; a new transaction
// may start in that same cycle, since busy is already low.
module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int ID_COUNT  = 32768,
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [FREE_ID_W-1:0] free_id,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [ID_W-1:0]           id
);

    localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int HINT_W     = $clog2(ID_COUNT + 1);
    localparam int LAST_BITS  = ID_COUNT % WORD_BITS;
    localparam int CMP_W      = ((HINT_W > FREE_ID_W) ? HINT_W : FREE_ID_W) + 1;
    localparam int DIV_SHIFT  = FREE_ID_W + $clog2(WORD_BITS);
    localparam int DIV_MULT   = ((2 ** DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int MUL_W      = FREE_ID_W + DIV_SHIFT + 2;

    localparam logic [ADDR_W-1:0]    LAST_WORD = ADDR_W'(WORD_COUNT - 1);
    localparam logic [HINT_W-1:0]    HINT_END  = HINT_W'(ID_COUNT);
    localparam logic [CMP_W-1:0]     ID_LIMIT  = CMP_W'(ID_COUNT);
    localparam logic [OFF_W-1:0]     LAST_OFF  = OFF_W'(WORD_BITS - 1);
    localparam logic [FREE_ID_W-1:0] WB_C      = FREE_ID_W'(WORD_BITS);
    localparam logic [HINT_W-1:0]    WB_H      = HINT_W'(WORD_BITS);
    localparam logic [MUL_W-1:0]     RECIP     = MUL_W'(DIV_MULT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FDIV,
        S_FREAD,
        S_FREE
    } state_t;

    state_t state_reg, state_next;

    logic [HINT_W-1:0]    hint_reg, hint_next;
    logic [ADDR_W-1:0]    hint_word_reg, hint_word_next;
    logic [OFF_W-1:0]     hint_off_reg, hint_off_next;
    logic [ADDR_W-1:0]    word_reg, word_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [HINT_W-1:0]    base_reg, base_next;
    logic                 first_reg, first_next;
    logic [FREE_ID_W-1:0] fid_reg, fid_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [ID_W-1:0]      id_reg, id_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_BITS-1:0] low_onehot;
    logic [OFF_W-1:0]     low_idx;
    logic                 found;
    logic [HINT_W-1:0]    found_id;
    logic                 accept;
    logic                 fid_in_range;
    logic [MUL_W-1:0]     quot_prod;
    logic [FREE_ID_W-1:0] rem_full;

    assign accept       = start && (state_reg == S_IDLE);
    assign fid_in_range = CMP_W'(free_id) < ID_LIMIT;
    assign quot_prod    = MUL_W'(fid_reg) * RECIP;
    assign rem_full     = fid_reg - FREE_ID_W'(word_reg) * WB_C;

    // Bits below the hint in the first word and bits past the last identifier
    // count as used, so the search never returns them.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            masked[b] = ram_rdata[b];
            if (first_reg && (OFF_W'(b) < hint_off_reg))
            begin
                masked[b] = 1'b1;
            end
            if ((LAST_BITS != 0) && (word_reg == LAST_WORD) && (b >= LAST_BITS))
            begin
                masked[b] = 1'b1;
            end
        end
    end

    assign free_vec   = ~masked;
    assign low_onehot = free_vec & (~free_vec + WORD_BITS'(1));
    assign found      = |free_vec;
    assign found_id   = base_reg + HINT_W'(low_idx);

    always_comb
    begin
        low_idx = '0;
        for (int k = 0; k < OFF_W; k++)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (((b >> k) & 1) == 1)
                begin
                    low_idx[k] = low_idx[k] | low_onehot[b];
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hint_next      = hint_reg;
        hint_word_next = hint_word_reg;
        hint_off_next  = hint_off_reg;
        word_next      = word_reg;
        off_next       = off_reg;
        base_next      = base_reg;
        first_next     = first_reg;
        fid_next       = fid_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        id_next        = id_reg;
        ram_we         = 1'b0;
        ram_addr       = hint_word_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = word_reg;
                ram_wdata = (word_reg == '0) ? WORD_BITS'(1) : '0;
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_ALLOC)
                    begin
                        if (hint_reg == HINT_END)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            id_next     = '0;
                        end
                        else
                        begin
                            word_next  = hint_word_reg;
                            base_next  = hint_reg - HINT_W'(hint_off_reg);
                            first_next = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    else if (fid_in_range)
                    begin
                        fid_next   = free_id;
                        state_next = S_FDIV;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FREED;
                        id_next     = '0;
                    end
                end
            end
            S_CHECK:
            begin
                if (found)
                begin
                    ram_we      = 1'b1;
                    ram_addr    = word_reg;
                    ram_wdata   = ram_rdata | low_onehot;
                    hint_next   = found_id + HINT_W'(1);
                    if (low_idx == LAST_OFF)
                    begin
                        hint_word_next = word_reg + ADDR_W'(1);
                        hint_off_next  = '0;
                    end
                    else
                    begin
                        hint_word_next = word_reg;
                        hint_off_next  = low_idx + OFF_W'(1);
                    end
                    done_next   = 1'b1;
                    status_next = ST_ALLOCATED;
                    id_next     = ID_W'(found_id);
                    state_next  = S_IDLE;
                end
                else if (word_reg == LAST_WORD)
                begin
                    hint_next   = HINT_END;
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    id_next     = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // Fetch the next word now so the scan covers one word a cycle.
                    ram_addr   = word_reg + ADDR_W'(1);
                    word_next  = word_reg + ADDR_W'(1);
                    base_next  = base_reg + WB_H;
                    first_next = 1'b0;
                end
            end
            S_FDIV:
            begin
                word_next  = ADDR_W'(quot_prod >> DIV_SHIFT);
                state_next = S_FREAD;
            end
            S_FREAD:
            begin
                ram_addr   = word_reg;
                off_next   = OFF_W'(rem_full);
                state_next = S_FREE;
            end
            S_FREE:
            begin
                ram_we    = 1'b1;
                ram_addr  = word_reg;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << off_reg);
                if (CMP_W'(fid_reg) < CMP_W'(hint_reg))
                begin
                    hint_next      = HINT_W'(fid_reg);
                    hint_word_next = word_reg;
                    hint_off_next  = off_reg;
                end
                done_next   = 1'b1;
                status_next = ST_FREED;
                id_next     = '0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hint_reg      <= HINT_W'(1);
            hint_word_reg <= '0;
            hint_off_reg  <= OFF_W'(1);
            word_reg      <= '0;
            off_reg       <= '0;
            base_reg      <= '0;
            first_reg     <= 1'b0;
            fid_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_ALLOCATED;
            id_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            hint_word_reg <= hint_word_next;
            hint_off_reg  <= hint_off_next;
            word_reg      <= word_next;
            off_reg       <= off_next;
            base_reg      <= base_next;
            first_reg     <= first_next;
            fid_reg       <= fid_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            id_reg        <= id_next;
        end
    end

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign id     = id_reg;

endmodule

`default_nettype wire

// ===== rtl/bia_checker.sv =====
// Port-level checks for the identifier allocator and the bind that attaches them.
`default_nettype none

module bia_checker
    import bia_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic [STATUS_W-1:0]  status,
    input wire logic [ID_W-1:0]      id
);

    // Only an allocation carries an identifier.
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_ALLOCATED) |-> id == '0)
        else $error("identifier nonzero on a non-allocate result");

    // An accepted transaction either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction neither answered nor in progress");

    // A result never appears out of nowhere.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy) || $past(busy))
        else $error("result without a transaction in flight");

    // Results are shown only once the block is ready for the next transaction.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .id       (id)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the bitmap identifier allocator.
`timescale 1ns / 100ps

module tb;
    import bia_pkg::*;

    localparam int ID_COUNT       = 32768;
    localparam int WORD_BITS      = 32;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 1100;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] id;
    } alloc_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [REQ_W-1:0]     req_type;
    logic [FREE_ID_W-1:0] free_id;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      id;

    // Expected state of the bitmap and the search hint.
    bit                   id_in_use [0:ID_COUNT-1];
    int unsigned          next_hint;
    alloc_result_t        pending_results [$];
    logic [ID_W-1:0]      held_ids [$];
    int                   mismatch_count = 0;
    int                   zero_gap_run = 0;
    int                   idle_cycles = 0;

    bitmap_id_allocator #(
        .ID_COUNT  (ID_COUNT),
        .WORD_BITS (WORD_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .free_id  (free_id),
        .done     (done),
        .status   (status),
        .id       (id)
    );

    always #5 clk = ~clk;

    function automatic logic [FREE_ID_W-1:0] rand_id(int unsigned hi);
        return FREE_ID_W'($urandom_range(0, hi));
    endfunction

    function automatic alloc_result_t predict_request(req_t kind, logic [FREE_ID_W-1:0] target);
        alloc_result_t result;
        int unsigned   n;
        result.status = ST_FREED;
        result.id     = '0;
        if (kind == REQ_ALLOC)
        begin
            n = next_hint;
            while (n < ID_COUNT && id_in_use[n])
                n++;
            if (n < ID_COUNT)
            begin
                id_in_use[n]  = 1'b1;
                next_hint     = n + 1;
                result.status = ST_ALLOCATED;
                result.id     = n[ID_W-1:0];
                held_ids.push_back(n[ID_W-1:0]);
            end
            else
            begin
                next_hint     = ID_COUNT;
                result.status = ST_FULL;
            end
        end
        else if (int'(target) < ID_COUNT)
        begin
            id_in_use[target] = 1'b0;
            if (32'(target) < next_hint)
                next_hint = 32'(target);
        end
        return result;
    endfunction

    function automatic void note_failure(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    // Sends one transaction after a random gap; start stays high afterwards so
    // that a back-to-back transaction needs no extra assignment.
    task automatic issue_request(input req_t kind, input logic [FREE_ID_W-1:0] target);
        int gap;
        if (zero_gap_run > 0)
        begin
            gap = 0;
            zero_gap_run--;
        end
        else
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 31) == 0)
                zero_gap_run = $urandom_range(4, 40);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        free_id  <= target;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_request(kind, target));
    endtask

    task automatic issue_free_of_held(input int range_hi);
        int              slot;
        logic [ID_W-1:0] target;
        if (held_ids.size() > 0)
        begin
            slot   = $urandom_range(0, held_ids.size() - 1);
            target = held_ids[slot];
            held_ids.delete(slot);
        end
        else
            target = rand_id(range_hi);
        issue_request(REQ_FREE, target);
    endtask

    task automatic test_directed_cases();
        issue_request(REQ_ALLOC, 15'h7FFF);
        issue_request(REQ_ALLOC, 15'h0000);
        issue_request(REQ_ALLOC, rand_id(32767));
        // Releasing the reserved identifier makes it available again.
        issue_request(REQ_FREE, 15'd0);
        issue_request(REQ_FREE, 15'd0);
        issue_request(REQ_ALLOC, 15'h2AAA);
        issue_request(REQ_ALLOC, 15'h5555);
        issue_request(REQ_FREE, 15'd2);
        issue_request(REQ_FREE, 15'd3);
        issue_request(REQ_ALLOC, rand_id(32767));
        issue_request(REQ_ALLOC, rand_id(32767));
        // Frees of identifiers that were never allocated, then of two that were.
        issue_request(REQ_FREE, 15'h7FFF);
        issue_request(REQ_FREE, 15'h5555);
        issue_request(REQ_FREE, 15'h2AAA);
        issue_request(REQ_FREE, 15'd4);
        issue_request(REQ_FREE, 15'd1);
        issue_request(REQ_ALLOC, rand_id(32767));
        issue_request(REQ_ALLOC, rand_id(32767));
        issue_request(REQ_ALLOC, rand_id(32767));
    endtask

    task automatic test_random_low_ids();
        int unsigned pick;
        repeat (300)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                issue_request(REQ_ALLOC, rand_id(32767));
            else if (pick < 80)
                issue_free_of_held(127);
            else if (pick < 92)
                issue_request(REQ_FREE, rand_id(127));
            else
                issue_request(REQ_FREE, rand_id(32767));
        end
    endtask

    // Allocates a run of identifiers in a row, then mixes random frees with
    // further allocations.
    task automatic test_alloc_run();
        repeat (20)
            issue_request(REQ_ALLOC, rand_id(32767));
        repeat (4)
        begin
            issue_request(REQ_FREE, rand_id(32767));
            issue_request(REQ_ALLOC, rand_id(32767));
            issue_request(REQ_ALLOC, rand_id(32767));
        end
    endtask

    // Frees spread over the whole range lower the hint now and then, so later
    // allocations scan across several used words.
    task automatic test_random_wide_ids();
        int unsigned pick;
        repeat (300)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                issue_request(REQ_ALLOC, rand_id(32767));
            else if (pick < 75)
                issue_free_of_held(32767);
            else if (pick < 95)
                issue_request(REQ_FREE, rand_id(32767));
            else
                issue_request(REQ_FREE, rand_id(63));
        end
    endtask

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("result with nothing pending: status %0d id %0d",
                                       status, id));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || id !== want.id)
                    note_failure($sformatf("expected status %0d id %0d, got status %0d id %0d",
                                           want.status, want.id, status, id));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("bitmap_id_allocator test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_ALLOC;
        free_id      = '0;
        id_in_use[0] = 1'b1;
        next_hint    = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_low_ids();
        test_alloc_run();
        test_random_wide_ids();

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("bitmap_id_allocator test passed");
        else
            $display("bitmap_id_allocator test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bia_pkg.sv
rtl/bia_ram.sv
rtl/bitmap_id_allocator.sv
rtl/bia_checker.sv
test/tb.sv
